>>> rtl/hsga_pkg.sv
`default_nettype none

package hsga_pkg;

  localparam int POS_W     = 7;
  localparam int SIZE_W    = 7;
  localparam int STEP_W    = 32;
  localparam int MAG_W     = 52;
  localparam int SRC_W     = 24;
  localparam int DST_W     = 21;
  localparam int IDX_W     = 12;
  localparam int ABS_W     = 8;
  localparam int SQ_W      = 15;
  localparam int PROD_W    = SQ_W + STEP_W;
  localparam int DPART_W   = 14;
  localparam int TBL_N     = 256;
  localparam int TBL_W     = 8;
  localparam int OFF_BIAS  = 62;
  localparam int CFG_IDX_W = 3;

  localparam logic [TBL_W-1:0] U_BIAS   = 8'd63;
  localparam logic [TBL_W-1:0] OFF_ZERO = 8'd62;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_SMALL_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SMALL_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SMALL_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_X_STEP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_Y_STEP  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_Z_STEP  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SHELL_L = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SHELL_H = 3'd7;

  localparam logic [SIZE_W-1:0] SIZE_RST  = 7'd127;
  localparam logic [STEP_W-1:0] STEP_RST  = 32'd16777216;
  localparam logic [MAG_W-1:0]  SHELL_LRST = '0;
  localparam logic [MAG_W-1:0]  SHELL_HRST = '1;

  typedef struct packed {
    logic [SIZE_W-1:0] small_x;
    logic [SIZE_W-1:0] small_y;
    logic [SIZE_W-1:0] small_z;
    logic [STEP_W-1:0] x_step;
    logic [STEP_W-1:0] y_step;
    logic [STEP_W-1:0] z_step;
    logic [MAG_W-1:0]  shell_lo;
    logic [MAG_W-1:0]  shell_hi;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0]         ix;
    logic [IDX_W-1:0]         iy;
    logic [IDX_W-1:0]         iz;
    logic                     conj;
    logic [POS_W-1:0]         px;
    logic [POS_W-1:0]         py;
    logic [POS_W-1:0]         pz;
    logic [SIZE_W-1:0]        sy;
    logic [SIZE_W-1:0]        sz;
    logic [ABS_W-1:0]         ax;
    logic [ABS_W-1:0]         ay;
    logic [ABS_W-1:0]         az;
    logic signed [POS_W-1:0]  cx;
    logic signed [POS_W-1:0]  cy;
    logic signed [POS_W-1:0]  cz;
  } entry_t;

endpackage

`default_nettype wire

>>> rtl/hsga_wrap.sv
`default_nettype none

module hsga_wrap
  import hsga_pkg::*;
#(
  parameter int N = 256
) (
  input  wire logic [TBL_W-1:0] u,
  output logic [IDX_W-1:0]      idx,
  output logic [IDX_W-1:0]      idx_mirror
);

  localparam int IW = $clog2(N);

  logic [IW-1:0] tbl [TBL_N];
  logic [IW-1:0] hit;
  logic [IW-1:0] neg;

  // entry g holds (g - bias) mod N
  for (genvar g = 0; g < TBL_N; g++) begin : g_tbl
    localparam int OFF = g - OFF_BIAS;
    localparam int R   = ((OFF % N) + N) % N;
    assign tbl[g] = IW'(R);
  end

  assign hit = tbl[u];
  assign neg = (hit == '0) ? '0 : (IW'(N) - hit);

  assign idx        = IDX_W'(hit);
  assign idx_mirror = IDX_W'(neg);

endmodule

`default_nettype wire

>>> rtl/hsga_front.sv
`default_nettype none

module hsga_front
  import hsga_pkg::*;
#(
  parameter int FFT_X     = 256,
  parameter int FFT_Y     = 256,
  parameter int FFT_Z     = 256,
  parameter int MAX_SMALL = 127
) (
  input  wire cfg_t             cfg,
  input  wire logic [POS_W-1:0] pos_x,
  input  wire logic [POS_W-1:0] pos_y,
  input  wire logic [POS_W-1:0] pos_z,
  output entry_t                entry
);

  localparam logic [SIZE_W-1:0] SIZE_CAP =
    (MAX_SMALL > 127) ? 7'd127 : SIZE_W'(MAX_SMALL);
  localparam logic [IDX_W-1:0] Z_HALF = IDX_W'(FFT_Z / 2);

  logic [SIZE_W-1:0] sx, sy, sz;
  logic [SIZE_W-2:0] hx, hy, hz;
  logic [TBL_W-1:0]  ux, uy, uz;
  logic [IDX_W-1:0]  wx, wy, wz, mx, my, mz;
  logic              conj;

  assign sx = (cfg.small_x > SIZE_CAP) ? SIZE_CAP : cfg.small_x;
  assign sy = (cfg.small_y > SIZE_CAP) ? SIZE_CAP : cfg.small_y;
  assign sz = (cfg.small_z > SIZE_CAP) ? SIZE_CAP : cfg.small_z;

  assign hx = sx[SIZE_W-1:1];
  assign hy = sy[SIZE_W-1:1];
  assign hz = sz[SIZE_W-1:1];

  // biased offset, pos - half + 1 + bias
  assign ux = {1'b0, pos_x} + U_BIAS - {2'b00, hx};
  assign uy = {1'b0, pos_y} + U_BIAS - {2'b00, hy};
  assign uz = {1'b0, pos_z} + U_BIAS - {2'b00, hz};

  hsga_wrap #(.N(FFT_X)) u_wrap_x (.u(ux), .idx(wx), .idx_mirror(mx));
  hsga_wrap #(.N(FFT_Y)) u_wrap_y (.u(uy), .idx(wy), .idx_mirror(my));
  hsga_wrap #(.N(FFT_Z)) u_wrap_z (.u(uz), .idx(wz), .idx_mirror(mz));

  // upper z half is not stored, take the mirrored point
  assign conj = (wz > Z_HALF);

  always_comb begin
    entry.ix   = conj ? mx : wx;
    entry.iy   = conj ? my : wy;
    entry.iz   = conj ? mz : wz;
    entry.conj = conj;
    entry.px   = pos_x;
    entry.py   = pos_y;
    entry.pz   = pos_z;
    entry.sy   = sy;
    entry.sz   = sz;
    entry.ax   = (ux >= OFF_ZERO) ? (ux - OFF_ZERO) : (OFF_ZERO - ux);
    entry.ay   = (uy >= OFF_ZERO) ? (uy - OFF_ZERO) : (OFF_ZERO - uy);
    entry.az   = (uz >= OFF_ZERO) ? (uz - OFF_ZERO) : (OFF_ZERO - uz);
    entry.cx   = pos_x - {1'b0, hx};
    entry.cy   = pos_y - {1'b0, hy};
    entry.cz   = pos_z - {1'b0, hz};
  end

endmodule

`default_nettype wire

>>> rtl/hsga_queue.sv
`default_nettype none

module hsga_queue
  import hsga_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push_valid,
  output logic        push_ready,
  input  wire entry_t push_data,
  output logic        pop_valid,
  input  wire logic   pop_ready,
  output entry_t      pop_data
);

  entry_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   count_r, count_nxt;
  logic                 push, pop;

  assign push_ready = (count_r != Q_CNT_W'(Q_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];

  assign push = push_valid && push_ready;
  assign pop  = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + Q_CNT_W'(push) - Q_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

>>> rtl/hsga_back.sv
`default_nettype none

module hsga_back
  import hsga_pkg::*;
#(
  parameter int FFT_Y = 256,
  parameter int FFT_Z = 256
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire cfg_t   cfg,
  input  wire logic   q_valid,
  output logic        q_ready,
  input  wire entry_t q_data,
  output logic        out_valid,
  input  wire logic   out_ready,
  output logic [SRC_W-1:0]        source_index,
  output logic                    conjugate,
  output logic [DST_W-1:0]        dest_index,
  output logic [MAG_W-1:0]        mag_sq,
  output logic                    in_shell,
  output logic signed [POS_W-1:0] centred_x,
  output logic signed [POS_W-1:0] centred_y,
  output logic signed [POS_W-1:0] centred_z
);

  localparam logic [SRC_W-1:0] ROW_Y  = SRC_W'(FFT_Y);
  localparam logic [SRC_W-1:0] ROW_Z  = SRC_W'(FFT_Z / 2 + 1);

  logic v1_r, v2_r, v3_r, v4_r;
  logic en1, en2, en3, en4;

  // stage 1: squares and inner address terms
  logic [SQ_W-1:0]          s1_sqx_r, s1_sqy_r, s1_sqz_r;
  logic [SRC_W-1:0]         s1_src_r;
  logic [DPART_W-1:0]       s1_dst_r;
  logic [IDX_W-1:0]         s1_iz_r;
  logic [POS_W-1:0]         s1_pz_r;
  logic [SIZE_W-1:0]        s1_sz_r;
  logic                     s1_conj_r;
  logic signed [POS_W-1:0]  s1_cx_r, s1_cy_r, s1_cz_r;

  // stage 2: step products and final addresses
  logic [PROD_W-1:0]        s2_px_r, s2_py_r, s2_pz_r;
  logic [SRC_W-1:0]         s2_src_r;
  logic [DST_W-1:0]         s2_dst_r;
  logic                     s2_conj_r;
  logic signed [POS_W-1:0]  s2_cx_r, s2_cy_r, s2_cz_r;

  // stage 3: magnitude sum
  logic [MAG_W-1:0]         s3_mag_r;
  logic [SRC_W-1:0]         s3_src_r;
  logic [DST_W-1:0]         s3_dst_r;
  logic                     s3_conj_r;
  logic signed [POS_W-1:0]  s3_cx_r, s3_cy_r, s3_cz_r;

  assign en4 = !v4_r || out_ready;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;

  assign q_ready   = en1;
  assign out_valid = v4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= q_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_sqx_r  <= SQ_W'(q_data.ax) * SQ_W'(q_data.ax);
      s1_sqy_r  <= SQ_W'(q_data.ay) * SQ_W'(q_data.ay);
      s1_sqz_r  <= SQ_W'(q_data.az) * SQ_W'(q_data.az);
      s1_src_r  <= SRC_W'(q_data.iy) + SRC_W'(q_data.ix) * ROW_Y;
      s1_dst_r  <= DPART_W'(q_data.py) + DPART_W'(q_data.sy) * DPART_W'(q_data.px);
      s1_iz_r   <= q_data.iz;
      s1_pz_r   <= q_data.pz;
      s1_sz_r   <= q_data.sz;
      s1_conj_r <= q_data.conj;
      s1_cx_r   <= q_data.cx;
      s1_cy_r   <= q_data.cy;
      s1_cz_r   <= q_data.cz;
    end
    if (en2) begin
      s2_px_r   <= PROD_W'(s1_sqx_r) * PROD_W'(cfg.x_step);
      s2_py_r   <= PROD_W'(s1_sqy_r) * PROD_W'(cfg.y_step);
      s2_pz_r   <= PROD_W'(s1_sqz_r) * PROD_W'(cfg.z_step);
      s2_src_r  <= SRC_W'(s1_iz_r) + s1_src_r * ROW_Z;
      s2_dst_r  <= DST_W'(s1_pz_r) + DST_W'(s1_sz_r) * DST_W'(s1_dst_r);
      s2_conj_r <= s1_conj_r;
      s2_cx_r   <= s1_cx_r;
      s2_cy_r   <= s1_cy_r;
      s2_cz_r   <= s1_cz_r;
    end
    if (en3) begin
      s3_mag_r  <= MAG_W'(s2_px_r) + MAG_W'(s2_py_r) + MAG_W'(s2_pz_r);
      s3_src_r  <= s2_src_r;
      s3_dst_r  <= s2_dst_r;
      s3_conj_r <= s2_conj_r;
      s3_cx_r   <= s2_cx_r;
      s3_cy_r   <= s2_cy_r;
      s3_cz_r   <= s2_cz_r;
    end
    if (en4) begin
      mag_sq       <= s3_mag_r;
      in_shell     <= (s3_mag_r >= cfg.shell_lo) && (s3_mag_r < cfg.shell_hi);
      source_index <= s3_src_r;
      dest_index   <= s3_dst_r;
      conjugate    <= s3_conj_r;
      centred_x    <= s3_cx_r;
      centred_y    <= s3_cy_r;
      centred_z    <= s3_cz_r;
    end
  end

endmodule

`default_nettype wire

>>> rtl/hermitian_subgrid_gather_address.sv
// channel   | handshake            | payload
// ----------+----------------------+------------------------------------------
// input     | in_valid / in_ready  | in_pos_x, in_pos_y, in_pos_z
// result    | out_valid / out_ready| out_source_index, out_conjugate,
//           |                      | out_dest_index, out_mag_sq, out_in_shell,
//           |                      | out_centred_x, out_centred_y, out_centred_z
// config    | cfg_we               | cfg_index, cfg_data
//
// one transaction per cycle sustained while out_ready stays high; each input transaction
// passes the queue and then the four-stage multiply/add pipeline of the back end
// a 4-entry queue between front end and back end keeps in_ready high while the
// result side stalls, until the queue and the pipeline are full
// rst_n is synchronous; there is no clearing pass, in_ready is high once reset has emptied the queue
`default_nettype none

module hermitian_subgrid_gather_address
  import hsga_pkg::*;
#(
  parameter int FFT_X     = 256,
  parameter int FFT_Y     = 256,
  parameter int FFT_Z     = 256,
  parameter int MAX_SMALL = 127
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [POS_W-1:0]       in_pos_x,
  input  wire logic [POS_W-1:0]       in_pos_y,
  input  wire logic [POS_W-1:0]       in_pos_z,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [SRC_W-1:0]            out_source_index,
  output logic                        out_conjugate,
  output logic [DST_W-1:0]            out_dest_index,
  output logic [MAG_W-1:0]            out_mag_sq,
  output logic                        out_in_shell,
  output logic signed [POS_W-1:0]     out_centred_x,
  output logic signed [POS_W-1:0]     out_centred_y,
  output logic signed [POS_W-1:0]     out_centred_z,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [MAG_W-1:0]       cfg_data
);

  cfg_t   cfg_r, cfg_nxt;
  entry_t front_entry;
  entry_t q_data;
  logic   q_valid, q_ready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_SMALL_X: cfg_nxt.small_x  = cfg_data[SIZE_W-1:0];
        REG_SMALL_Y: cfg_nxt.small_y  = cfg_data[SIZE_W-1:0];
        REG_SMALL_Z: cfg_nxt.small_z  = cfg_data[SIZE_W-1:0];
        REG_X_STEP:  cfg_nxt.x_step   = cfg_data[STEP_W-1:0];
        REG_Y_STEP:  cfg_nxt.y_step   = cfg_data[STEP_W-1:0];
        REG_Z_STEP:  cfg_nxt.z_step   = cfg_data[STEP_W-1:0];
        REG_SHELL_L: cfg_nxt.shell_lo = cfg_data;
        REG_SHELL_H: cfg_nxt.shell_hi = cfg_data;
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.small_x  <= SIZE_RST;
      cfg_r.small_y  <= SIZE_RST;
      cfg_r.small_z  <= SIZE_RST;
      cfg_r.x_step   <= STEP_RST;
      cfg_r.y_step   <= STEP_RST;
      cfg_r.z_step   <= STEP_RST;
      cfg_r.shell_lo <= SHELL_LRST;
      cfg_r.shell_hi <= SHELL_HRST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  hsga_front #(
    .FFT_X     (FFT_X),
    .FFT_Y     (FFT_Y),
    .FFT_Z     (FFT_Z),
    .MAX_SMALL (MAX_SMALL)
  ) u_front (
    .cfg   (cfg_r),
    .pos_x (in_pos_x),
    .pos_y (in_pos_y),
    .pos_z (in_pos_z),
    .entry (front_entry)
  );

  hsga_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_data  (front_entry),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  hsga_back #(
    .FFT_Y (FFT_Y),
    .FFT_Z (FFT_Z)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_data       (q_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .source_index (out_source_index),
    .conjugate    (out_conjugate),
    .dest_index   (out_dest_index),
    .mag_sq       (out_mag_sq),
    .in_shell     (out_in_shell),
    .centred_x    (out_centred_x),
    .centred_y    (out_centred_y),
    .centred_z    (out_centred_z)
  );

endmodule

`default_nettype wire

>>> rtl/hsga_checker.sv
`default_nettype none

module hsga_checker
  import hsga_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic [SRC_W-1:0]     out_source_index,
  input wire logic                 out_conjugate,
  input wire logic [DST_W-1:0]     out_dest_index,
  input wire logic [MAG_W-1:0]     out_mag_sq,
  input wire logic                 out_in_shell
);

  logic [3:0] pending_r, pending_nxt;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_comb begin
    pending_nxt = pending_r + 4'(in_acc) - 4'(out_acc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_source_index)
      && $stable(out_conjugate) && $stable(out_dest_index)
      && $stable(out_mag_sq) && $stable(out_in_shell))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // no result without an outstanding transaction
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != '0)
    else $error("result without input transaction");

  // three products below 2^47 never reach the top bits
  a_mag_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_mag_sq[MAG_W-1:MAG_W-3] == 3'b000)
    else $error("magnitude out of range");

endmodule

bind hermitian_subgrid_gather_address hsga_checker u_hsga_checker (.*);

`default_nettype wire

>>> dv/tb.sv
`default_nettype none

module tb;
  import hsga_pkg::*;

  localparam int FFT_X       = 256;
  localparam int FFT_Y       = 256;
  localparam int FFT_Z       = 256;
  localparam int MAX_SMALL   = 127;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_WAIT  = 8;

  typedef struct packed {
    logic [SRC_W-1:0]        source_index;
    logic                    conjugate;
    logic [DST_W-1:0]        dest_index;
    logic [MAG_W-1:0]        mag_sq;
    logic                    in_shell;
    logic signed [POS_W-1:0] centred_x;
    logic signed [POS_W-1:0] centred_y;
    logic signed [POS_W-1:0] centred_z;
  } gather_result_t;

  typedef struct packed {
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [POS_W-1:0] z;
    logic             typed;
    gather_result_t   res;
  } point_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [POS_W-1:0]     in_pos_x;
  logic [POS_W-1:0]     in_pos_y;
  logic [POS_W-1:0]     in_pos_z;
  logic                 out_valid;
  logic                 out_ready;
  logic [SRC_W-1:0]     out_source_index;
  logic                 out_conjugate;
  logic [DST_W-1:0]     out_dest_index;
  logic [MAG_W-1:0]     out_mag_sq;
  logic                 out_in_shell;
  logic signed [POS_W-1:0] out_centred_x;
  logic signed [POS_W-1:0] out_centred_y;
  logic signed [POS_W-1:0] out_centred_z;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [MAG_W-1:0]     cfg_data;

  cfg_t           cur_cfg;
  gather_result_t pending_gathers[$];
  gather_result_t oldest_gather;
  int             in_gap_mode;
  int             stall_mode;
  int             fail_cnt;
  int             points_sent;
  int             results_seen;
  int             mirrored_cnt;
  int             shell_hits;
  int             phase_cnt;
  int             cycle_cnt;

  // reset register values, zero offset at the centre, both far corners
  point_row_t directed_points [0:9] = '{
    '{7'd62,  7'd62,  7'd62,  1'b1,
      '{24'd0, 1'b0, 21'd1007934, 52'd0, 1'b1, 7'h7F, 7'h7F, 7'h7F}},
    '{7'd0,   7'd0,   7'd0,   1'b1,
      '{24'd2055548, 1'b1, 21'd0, 52'd11532 << 24, 1'b1, 7'h41, 7'h41, 7'h41}},
    '{7'd126, 7'd126, 7'd126, 1'b1,
      '{24'd2121856, 1'b0, 21'd2048382, 52'd12288 << 24, 1'b1, 7'h3F, 7'h3F, 7'h3F}},
    '{7'd127, 7'd127, 7'd127, 1'b0, '0},
    '{7'd127, 7'd0,   7'd64,  1'b0, '0},
    '{7'd0,   7'd127, 7'd1,   1'b0, '0},
    '{7'd63,  7'd61,  7'd63,  1'b0, '0},
    '{7'd1,   7'd2,   7'd126, 1'b0, '0},
    '{7'd64,  7'd64,  7'd0,   1'b0, '0},
    '{7'd0,   7'd126, 7'd127, 1'b0, '0}
  };

  hermitian_subgrid_gather_address #(
    .FFT_X     (FFT_X),
    .FFT_Y     (FFT_Y),
    .FFT_Z     (FFT_Z),
    .MAX_SMALL (MAX_SMALL)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_pos_z         (in_pos_z),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_source_index (out_source_index),
    .out_conjugate    (out_conjugate),
    .out_dest_index   (out_dest_index),
    .out_mag_sq       (out_mag_sq),
    .out_in_shell     (out_in_shell),
    .out_centred_x    (out_centred_x),
    .out_centred_y    (out_centred_y),
    .out_centred_z    (out_centred_z),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic longint wrap_mod(input longint off, input longint n);
    longint r;
    r = off % n;
    if (r < 0) begin
      r += n;
    end
    return r;
  endfunction

  function automatic gather_result_t predict_gather(input cfg_t c, input logic [POS_W-1:0] px,
                                                    input logic [POS_W-1:0] py,
                                                    input logic [POS_W-1:0] pz);
    longint sx, sy, sz, ox, oy, oz, ix, iy, iz;
    longint unsigned mag;
    gather_result_t r;
    sx = (c.small_x > MAX_SMALL) ? MAX_SMALL : longint'(c.small_x);
    sy = (c.small_y > MAX_SMALL) ? MAX_SMALL : longint'(c.small_y);
    sz = (c.small_z > MAX_SMALL) ? MAX_SMALL : longint'(c.small_z);
    ox = longint'(px) - (sx / 2 - 1);
    oy = longint'(py) - (sy / 2 - 1);
    oz = longint'(pz) - (sz / 2 - 1);
    ix = wrap_mod(ox, FFT_X);
    iy = wrap_mod(oy, FFT_Y);
    iz = wrap_mod(oz, FFT_Z);
    r.conjugate = 1'b0;
    if (iz > FFT_Z / 2) begin
      ix = wrap_mod(-ox, FFT_X);
      iy = wrap_mod(-oy, FFT_Y);
      iz = wrap_mod(-oz, FFT_Z);
      r.conjugate = 1'b1;
    end
    r.source_index = SRC_W'(iz + (FFT_Z / 2 + 1) * (iy + FFT_Y * ix));
    r.dest_index   = DST_W'(longint'(pz) + sz * (longint'(py) + sy * longint'(px)));
    mag = longint'(ox * ox) * longint'(c.x_step) + longint'(oy * oy) * longint'(c.y_step)
        + longint'(oz * oz) * longint'(c.z_step);
    r.mag_sq    = MAG_W'(mag);
    r.in_shell  = (r.mag_sq >= c.shell_lo) && (r.mag_sq < c.shell_hi);
    r.centred_x = POS_W'(longint'(px) - sx / 2);
    r.centred_y = POS_W'(longint'(py) - sy / 2);
    r.centred_z = POS_W'(longint'(pz) - sz / 2);
    return r;
  endfunction

  function automatic logic [MAG_W-1:0] random_word();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[MAG_W-1:0];
  endfunction

  function automatic int pick_gap(input int mode);
    int r;
    if (mode == 0) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 96) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  // mostly inside the box, sometimes anywhere in the field
  function automatic logic [POS_W-1:0] rand_coord(input logic [SIZE_W-1:0] size);
    if (size == 0 || $urandom_range(0, 6) == 0) begin
      return POS_W'($urandom_range(0, 127));
    end
    return POS_W'($urandom_range(0, size - 1));
  endfunction

  function automatic logic [SIZE_W-1:0] rand_size();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      return SIZE_W'($urandom_range(0, 2));
    end else if (r == 1) begin
      return 7'd127;
    end else if (r == 2) begin
      return SIZE_W'($urandom_range(1, 63) * 2);
    end
    return SIZE_W'($urandom_range(1, 63) * 2 + 1);
  endfunction

  function automatic logic [STEP_W-1:0] rand_step();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      return 32'd1;
    end else if (r == 1) begin
      return 32'hFFFF_FFFF;
    end else if (r < 4) begin
      return $urandom;
    end
    return $urandom_range(32'h0010_0000, 32'h1000_0000);
  endfunction

  // shell bounds mostly taken from magnitudes of points of this setting, at times reversed, random or left fully open
  function automatic cfg_t random_config();
    cfg_t c;
    gather_result_t g0, g1;
    logic [MAG_W-1:0] m0, m1, tmp;
    int r;
    c.small_x  = rand_size();
    c.small_y  = rand_size();
    c.small_z  = rand_size();
    c.x_step   = rand_step();
    c.y_step   = rand_step();
    c.z_step   = rand_step();
    c.shell_lo = '0;
    c.shell_hi = '1;
    g0 = predict_gather(c, rand_coord(c.small_x), rand_coord(c.small_y), rand_coord(c.small_z));
    g1 = predict_gather(c, rand_coord(c.small_x), rand_coord(c.small_y), rand_coord(c.small_z));
    m0 = g0.mag_sq;
    m1 = g1.mag_sq;
    if (m0 > m1) begin
      tmp = m0;
      m0  = m1;
      m1  = tmp;
    end
    r = $urandom_range(0, 9);
    if (r == 1) begin
      c.shell_lo = m1;
      c.shell_hi = m0;
    end else if (r == 2) begin
      c.shell_lo = random_word();
      c.shell_hi = random_word();
    end else if (r > 2) begin
      c.shell_lo = m0;
      c.shell_hi = m1 + 1;
    end
    return c;
  endfunction

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [MAG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_SMALL_X: cur_cfg.small_x  = data[SIZE_W-1:0];
      REG_SMALL_Y: cur_cfg.small_y  = data[SIZE_W-1:0];
      REG_SMALL_Z: cur_cfg.small_z  = data[SIZE_W-1:0];
      REG_X_STEP:  cur_cfg.x_step   = data[STEP_W-1:0];
      REG_Y_STEP:  cur_cfg.y_step   = data[STEP_W-1:0];
      REG_Z_STEP:  cur_cfg.z_step   = data[STEP_W-1:0];
      REG_SHELL_L: cur_cfg.shell_lo = data;
      REG_SHELL_H: cur_cfg.shell_hi = data;
      default: ;
    endcase
  endtask

  task automatic send_point(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                            input logic [POS_W-1:0] z, input logic typed,
                            input gather_result_t typed_res);
    int gap;
    gap = pick_gap(in_gap_mode);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pos_x <= x;
    in_pos_y <= y;
    in_pos_z <= z;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    pending_gathers.insert(pending_gathers.size(),
                           typed ? typed_res : predict_gather(cur_cfg, x, y, z));
    points_sent++;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_gathers.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic run_phase(input cfg_t c, input int n_points, input bit corners);
    logic [MAG_W-1:0] junk;
    junk = random_word();
    write_register(REG_SMALL_X, {junk[MAG_W-1:SIZE_W], c.small_x});
    write_register(REG_SMALL_Y, {junk[MAG_W-1:SIZE_W], c.small_y});
    write_register(REG_SMALL_Z, {~junk[MAG_W-1:SIZE_W], c.small_z});
    write_register(REG_X_STEP,  {junk[MAG_W-1:STEP_W], c.x_step});
    write_register(REG_Y_STEP,  {~junk[MAG_W-1:STEP_W], c.y_step});
    write_register(REG_Z_STEP,  {junk[STEP_W-1:12], c.z_step});
    write_register(REG_SHELL_L, c.shell_lo);
    write_register(REG_SHELL_H, c.shell_hi);
    cfg_we      <= 1'b0;
    in_gap_mode = $urandom_range(0, 2);
    stall_mode  = $urandom_range(0, 2);
    phase_cnt++;
    if (corners) begin
      for (int k = 0; k < 8; k++) begin
        send_point(k[0] ? 7'd127 : 7'd0, k[1] ? 7'd127 : 7'd0, k[2] ? 7'd127 : 7'd0,
                   1'b0, '0);
      end
    end
    for (int n = 0; n < n_points; n++) begin
      send_point(rand_coord(cur_cfg.small_x), rand_coord(cur_cfg.small_y),
                 rand_coord(cur_cfg.small_z), 1'b0, '0);
    end
    drain();
  endtask

  initial begin
    int run_len;
    int stall_len;
    out_ready <= 1'b0;
    forever begin
      run_len = $urandom_range(1, 16);
      repeat (run_len) begin
        @(posedge clk);
        out_ready <= 1'b1;
      end
      stall_len = pick_gap(stall_mode);
      repeat (stall_len) begin
        @(posedge clk);
        out_ready <= 1'b0;
      end
    end
  end

  function automatic void check_field(input string name, input logic [63:0] exp_v,
                                      input logic [63:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected 'h%0h, got 'h%0h", name, exp_v, got_v);
      fail_cnt++;
    end
  endfunction

  always @(negedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_gathers.size() == 0) begin
        $error("result transaction with no point outstanding");
        fail_cnt++;
      end else begin
        oldest_gather = pending_gathers.pop_front();
        results_seen++;
        mirrored_cnt += oldest_gather.conjugate;
        shell_hits   += oldest_gather.in_shell;
        check_field("source_index", oldest_gather.source_index, out_source_index);
        check_field("conjugate", oldest_gather.conjugate, out_conjugate);
        check_field("dest_index", oldest_gather.dest_index, out_dest_index);
        check_field("mag_sq", oldest_gather.mag_sq, out_mag_sq);
        check_field("in_shell", oldest_gather.in_shell, out_in_shell);
        check_field("centred_x", oldest_gather.centred_x, out_centred_x);
        check_field("centred_y", oldest_gather.centred_y, out_centred_y);
        check_field("centred_z", oldest_gather.centred_z, out_centred_z);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $error("run stopped after %0d cycles, %0d results outstanding", cycle_cnt,
             pending_gathers.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    cfg_t c;
    cycle_cnt    = 0;
    fail_cnt     = 0;
    points_sent  = 0;
    results_seen = 0;
    mirrored_cnt = 0;
    shell_hits   = 0;
    phase_cnt    = 1;
    in_gap_mode  = 0;
    stall_mode   = 0;
    cur_cfg      = '{SIZE_RST, SIZE_RST, SIZE_RST, STEP_RST, STEP_RST, STEP_RST,
                     SHELL_LRST, SHELL_HRST};
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_pos_x  <= '0;
    in_pos_y  <= '0;
    in_pos_z  <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_SMALL_X;
    cfg_data  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    in_gap_mode = 1;
    stall_mode  = 1;
    for (int i = 0; i < $size(directed_points); i++) begin
      send_point(directed_points[i].x, directed_points[i].y, directed_points[i].z,
                 directed_points[i].typed, directed_points[i].res);
    end
    drain();

    // tiny and zero edges, widest steps, empty shell
    c = '{7'd1, 7'd0, 7'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1, '0};
    run_phase(c, 40, 1'b1);
    c = '{7'd127, 7'd127, 7'd127, 32'd1, 32'd1, 32'd1, 52'd100, 52'd2000};
    run_phase(c, 40, 1'b1);
    c = '{7'd126, 7'd64, 7'd3, 32'd0, 32'h8000_0000, STEP_RST, 52'd16777216, 52'd1 << 48};
    run_phase(c, 40, 1'b1);
    for (int p = 0; p < 14; p++) begin
      run_phase(random_config(), $urandom_range(70, 130), 1'b0);
    end

    $display("%0d points in %0d register settings, %0d results checked", points_sent,
             phase_cnt, results_seen);
    $display("%0d needed conjugation, %0d fell inside the shell", mirrored_cnt, shell_hits);
    if (fail_cnt == 0 && pending_gathers.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
